/* sv/bdh_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the button debounce / hold block.
// No dependencies; imported by bdh_step, button_debounce_hold_fsm_top, bdh_scoreboard_pkg and the testbench.
package bdh_pkg;

   // One-hot per-button state
   typedef enum logic [5:0] {
      ST_RELEASED    = 6'b000001,
      ST_PRE_PUSH    = 6'b000010,
      ST_PUSHED      = 6'b000100,
      ST_PRE_HOLD    = 6'b001000,
      ST_HOLD        = 6'b010000,
      ST_PRE_RELEASE = 6'b100000
   } state_type;

   // Encoded state as reported on the result channel
   localparam logic [2:0] CODE_RELEASED    = 3'd0;
   localparam logic [2:0] CODE_PRE_PUSH    = 3'd1;
   localparam logic [2:0] CODE_PUSHED      = 3'd2;
   localparam logic [2:0] CODE_PRE_HOLD    = 3'd3;
   localparam logic [2:0] CODE_HOLD        = 3'd4;
   localparam logic [2:0] CODE_PRE_RELEASE = 3'd5;

   // Configuration register indexes (byte address / 4)
   localparam logic [1:0] REG_DEBOUNCE_LIMIT = 2'd0;
   localparam logic [1:0] REG_HOLD_LIMIT     = 2'd1;
   localparam logic [1:0] REG_PRESSED_LEVEL  = 2'd2;

   localparam logic [7:0] DEBOUNCE_LIMIT_RST = 8'd5;
   localparam logic [7:0] HOLD_LIMIT_RST     = 8'd50;
   localparam logic       PRESSED_LEVEL_RST  = 1'b0;

   // Per-button record: state plus both counters
   typedef struct packed {
      state_type  state;
      logic [7:0] debounce_count;
      logic [7:0] hold_count;
   } entry_type;

   localparam entry_type ENTRY_RST = '{state: ST_RELEASED, debounce_count: 8'd0,
                                       hold_count: 8'd0};

   // Encode one-hot state to the 3-bit reported code
   function automatic logic [2:0] state_code(input state_type st);
      logic [2:0] code;
      case (st)
         ST_RELEASED:    code = CODE_RELEASED;
         ST_PRE_PUSH:    code = CODE_PRE_PUSH;
         ST_PUSHED:      code = CODE_PUSHED;
         ST_PRE_HOLD:    code = CODE_PRE_HOLD;
         ST_HOLD:        code = CODE_HOLD;
         ST_PRE_RELEASE: code = CODE_PRE_RELEASE;
         default:        code = CODE_RELEASED;
      endcase
      return code;
   endfunction

endpackage

/* sv/bdh_step.sv */
`timescale 1ns / 1ps
// Next-state logic for one button: state machine plus debounce and hold counters.
// Depends on bdh_pkg.
module bdh_step
   import bdh_pkg::*;
(
   input  entry_type  cur,
   input  logic       pressed,
   input  logic [7:0] debounce_limit,
   input  logic [7:0] hold_limit,
   output entry_type  nxt
);

   logic [7:0] deb_inc;
   logic [7:0] hold_inc;

   assign deb_inc  = cur.debounce_count + 8'd1;
   assign hold_inc = cur.hold_count + 8'd1;

   // Advance the machine by one sampling tick
   always_comb begin
      nxt = cur;
      case (cur.state)
         ST_RELEASED: begin
            if (pressed) begin
               nxt.debounce_count = 8'd0;
               nxt.state          = ST_PRE_PUSH;
            end
         end
         ST_PRE_PUSH: begin
            if (!pressed) begin
               nxt.debounce_count = 8'd0;
               nxt.state          = ST_PRE_RELEASE;
            end else begin
               nxt.debounce_count = deb_inc;
               if (deb_inc == debounce_limit) begin
                  nxt.state = ST_PUSHED;
               end
            end
         end
         ST_PUSHED: begin
            if (!pressed) begin
               nxt.debounce_count = 8'd0;
               nxt.state          = ST_PRE_RELEASE;
            end else begin
               nxt.hold_count = 8'd0;
               nxt.state      = ST_PRE_HOLD;
            end
         end
         ST_PRE_HOLD: begin
            if (!pressed) begin
               nxt.debounce_count = 8'd0;
               nxt.state          = ST_PRE_RELEASE;
            end else begin
               nxt.hold_count = hold_inc;
               if (hold_inc >= hold_limit) begin
                  nxt.state = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (!pressed) begin
               nxt.debounce_count = 8'd0;
               nxt.state          = ST_PRE_RELEASE;
            end
         end
         ST_PRE_RELEASE: begin
            if (!pressed) begin
               nxt.debounce_count = deb_inc;
               if (deb_inc == debounce_limit) begin
                  nxt.state = ST_RELEASED;
               end
            end else begin
               nxt.debounce_count = 8'd0;
               nxt.state          = ST_PRE_PUSH;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

/* sv/button_debounce_hold_fsm_top.sv */
`timescale 1ns / 1ps
// Button debounce with long-press detection, top level.
// A beat accepted on the input channel is captured in the input register, and its
// result is loaded into the output register when the result channel can take it.
// Throughput: one beat per cycle unless rsp stalls; the per-button table is read and written in one pass.
// Reset (synchronous): all buttons released, counters zero, limits back to defaults.
module button_debounce_hold_fsm_top
   import bdh_pkg::*;
#(
   parameter int NUM_BUTTONS = 4
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_button_index,
   input  logic        req_pin_level,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_button_number,
   output logic [2:0]  rsp_button_state,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   // Configuration registers
   logic [7:0] debounce_limit_ff;
   logic [7:0] hold_limit_ff;
   logic       pressed_level_ff;
   logic       csr_wr;
   logic [1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_limit_ff <= DEBOUNCE_LIMIT_RST;
         hold_limit_ff     <= HOLD_LIMIT_RST;
         pressed_level_ff  <= PRESSED_LEVEL_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_DEBOUNCE_LIMIT: debounce_limit_ff <= csr_pwdata[7:0];
            REG_HOLD_LIMIT:     hold_limit_ff     <= csr_pwdata[7:0];
            REG_PRESSED_LEVEL:  pressed_level_ff  <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      case (csr_idx)
         REG_DEBOUNCE_LIMIT: csr_prdata = {24'd0, debounce_limit_ff};
         REG_HOLD_LIMIT:     csr_prdata = {24'd0, hold_limit_ff};
         REG_PRESSED_LEVEL:  csr_prdata = {31'd0, pressed_level_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // Input register stage
   logic       in_valid_ff;
   logic [1:0] in_idx_ff;
   logic       in_pin_ff;
   logic       advance;

   assign advance   = in_valid_ff & (~rsp_valid | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_idx_ff <= req_button_index;
         in_pin_ff <= req_pin_level;
      end
   end

   // Per-button table and next-state logic
   entry_type             table_ff [NUM_BUTTONS];
   logic [IDX_W-1:0]      sel;
   logic                  in_range;
   entry_type             cur_entry;
   entry_type             nxt_entry;

   assign sel       = IDX_W'(in_idx_ff);
   assign in_range  = (32'(in_idx_ff) < NUM_BUTTONS);
   assign cur_entry = table_ff[sel];

   bdh_step u_step (
      .cur            (cur_entry),
      .pressed        (in_pin_ff == pressed_level_ff),
      .debounce_limit (debounce_limit_ff),
      .hold_limit     (hold_limit_ff),
      .nxt            (nxt_entry)
   );

   // Write back the updated entry as the beat moves to the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            table_ff[i] <= ENTRY_RST;
         end
      end else if (advance && in_range) begin
         table_ff[sel] <= nxt_entry;
      end
   end

   // Output register stage
   logic       rsp_valid_ff;
   logic [1:0] rsp_num_ff;
   logic [2:0] rsp_state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_num_ff   <= in_idx_ff;
         rsp_state_ff <= in_range ? state_code(nxt_entry.state) : CODE_RELEASED;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_button_number = rsp_num_ff;
   assign rsp_button_state  = rsp_state_ff;

endmodule

/* verif/bdh_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the button debounce / hold block: per-button state prediction and result checks.
// Depends on bdh_pkg for the reported state codes and the register indexes.
package bdh_scoreboard_pkg;
   import bdh_pkg::*;

   // One expected result beat
   typedef struct {
      logic [1:0] number;
      logic [2:0] state;
   } report_type;

   class button_scoreboard;
      int unsigned buttons;
      int unsigned fail_count;

      // Shared limits, mirrored from register writes
      logic [7:0] confirm_ticks;
      logic [7:0] long_press_ticks;
      logic       active_level;

      // Per-button prediction state
      logic [2:0] phase_code [];
      logic [7:0] bounce_count [];
      logic [7:0] press_ticks [];

      report_type pending_reports [$];

      function new(int unsigned n);
         buttons = n;
         fail_count = 0;
         confirm_ticks = DEBOUNCE_LIMIT_RST;
         long_press_ticks = HOLD_LIMIT_RST;
         active_level = PRESSED_LEVEL_RST;
         phase_code = new[n];
         bounce_count = new[n];
         press_ticks = new[n];
         foreach (phase_code[i]) begin
            phase_code[i] = CODE_RELEASED;
            bounce_count[i] = 8'd0;
            press_ticks[i] = 8'd0;
         end
      endfunction

      // Mirror a register write; only the low bits of each register count
      function void write_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_DEBOUNCE_LIMIT: confirm_ticks = value[7:0];
            REG_HOLD_LIMIT:     long_press_ticks = value[7:0];
            REG_PRESSED_LEVEL:  active_level = value[0];
            default: ;
         endcase
      endfunction

      function void enter_pre_release(int unsigned b);
         bounce_count[b] = 8'd0;
         phase_code[b] = CODE_PRE_RELEASE;
      endfunction

      // Advance one button's machine by one sampling tick
      function void advance_button(int unsigned b, bit pressed);
         case (phase_code[b])
            CODE_RELEASED: begin
               if (pressed) begin
                  bounce_count[b] = 8'd0;
                  phase_code[b] = CODE_PRE_PUSH;
               end
            end
            CODE_PRE_PUSH: begin
               if (!pressed) enter_pre_release(b);
               else begin
                  bounce_count[b] = bounce_count[b] + 8'd1;
                  if (bounce_count[b] == confirm_ticks) phase_code[b] = CODE_PUSHED;
               end
            end
            CODE_PUSHED: begin
               if (!pressed) enter_pre_release(b);
               else begin
                  press_ticks[b] = 8'd0;
                  phase_code[b] = CODE_PRE_HOLD;
               end
            end
            CODE_PRE_HOLD: begin
               if (!pressed) enter_pre_release(b);
               else begin
                  press_ticks[b] = press_ticks[b] + 8'd1;
                  if (press_ticks[b] >= long_press_ticks) phase_code[b] = CODE_HOLD;
               end
            end
            CODE_HOLD: begin
               if (!pressed) enter_pre_release(b);
            end
            CODE_PRE_RELEASE: begin
               if (!pressed) begin
                  bounce_count[b] = bounce_count[b] + 8'd1;
                  if (bounce_count[b] == confirm_ticks) phase_code[b] = CODE_RELEASED;
               end else begin
                  bounce_count[b] = 8'd0;
                  phase_code[b] = CODE_PRE_PUSH;
               end
            end
            default: ;
         endcase
      endfunction

      // Note an accepted tick and queue the state it should report
      function void note_tick(logic [1:0] idx, logic pin);
         report_type exp;
         exp.number = idx;
         exp.state = CODE_RELEASED;
         if (idx < buttons) begin
            advance_button(idx, pin == active_level);
            exp.state = phase_code[idx];
         end
         pending_reports.push_back(exp);
      endfunction

      function void flag(string msg);
         fail_count++;
         if (fail_count <= 10) $display("mismatch: %s", msg);
      endfunction

      // Compare an accepted result beat against the oldest expectation
      function void check_report(logic [1:0] number, logic [2:0] st);
         report_type exp;
         if (pending_reports.size() == 0) begin
            flag($sformatf("result with nothing expected: button %0d state %0d", number, st));
            return;
         end
         exp = pending_reports.pop_front();
         if (number !== exp.number)
            flag($sformatf("button_number expected %0d got %0d", exp.number, number));
         if (st !== exp.state)
            flag($sformatf("button %0d button_state expected %0d got %0d",
                           exp.number, exp.state, st));
      endfunction

      function int unsigned outstanding();
         return pending_reports.size();
      endfunction
   endclass

endpackage

/* verif/button_debounce_hold_fsm_top_test.sv */
`timescale 1ns / 1ps
// Testbench for button_debounce_hold_fsm_top: directed ticks, then random press/release runs
// under several limit settings with random idling. Depends on bdh_pkg and bdh_scoreboard_pkg.
module button_debounce_hold_fsm_top_test;
   import bdh_pkg::*;
   import bdh_scoreboard_pkg::*;

   localparam int BUTTONS = 4;
   localparam int IDLE_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_button_index;
   logic        req_pin_level;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_button_number;
   logic [2:0]  rsp_button_state;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   button_scoreboard sb;
   bit          idle_on = 1'b1;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;

   button_debounce_hold_fsm_top #(.NUM_BUTTONS(BUTTONS)) dut (.*);

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Stall the result channel in random bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // Check every accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_report(rsp_button_number, rsp_button_state);
   end

   // Watchdog: give up when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** button_debounce_hold_fsm_top: FAILED **");
            $finish;
         end
      end
   end

   // Register write: setup cycle, then access cycle
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Set all limits; upper data bits carry random junk
   task automatic apply_limits(input logic [7:0] db, input logic [7:0] hl, input logic pl);
      write_reg(REG_DEBOUNCE_LIMIT, ($urandom() & 32'hFFFF_FF00) | db);
      write_reg(REG_HOLD_LIMIT, ($urandom() & 32'hFFFF_FF00) | hl);
      write_reg(REG_PRESSED_LEVEL, ($urandom() & 32'hFFFF_FFFE) | pl);
   endtask

   // Drive one tick beat, with an optional gap ahead of it
   task automatic send_tick(input logic [1:0] b, input logic pin);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_button_index = b;
      req_pin_level = pin;
      do @(posedge clock); while (req_stall);
      sb.note_tick(b, pin);
   endtask

   // Drop valid, then wait until every expected result has come, plus the pipeline depth
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Random phase: runs of steady levels per button, some with bounces
   task automatic run_phase(input logic [7:0] db, input logic [7:0] hl, input logic pl,
                            input int n_items, input bit quiet);
      int sent;
      int run_len;
      int span;
      bit bouncy;
      logic [1:0] b;
      logic lvl;
      apply_limits(db, hl, pl);
      span = (db == 0) ? 256 : db;
      sent = 0;
      while (sent < n_items) begin
         b = 2'($urandom_range(0, 3));
         lvl = 1'($urandom_range(0, 1));
         bouncy = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0) run_len = $urandom_range(1, span + 1);
         else run_len = $urandom_range(span + 1, span + hl + 12);
         for (int k = 0; k < run_len && sent < n_items; k++) begin
            if (sent % 64 == 0) idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 11) != 0) send_tick(b, lvl);
            else if (bouncy) send_tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            else send_tick(2'(b + $urandom_range(1, 3)), 1'($urandom_range(0, 1)));
            sent++;
         end
      end
      drain();
   endtask

   initial begin
      // Directed walk: pressed level is 0 here, so pin 1 means released
      bit [1:0] dir_btn [24] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                 3, 3, 3, 3, 3, 1, 1, 1, 1, 1};
      bit       dir_pin [24] = '{1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1,
                                 0, 0, 0, 1, 0, 0, 0, 0, 0, 1};
      sb = new(BUTTONS);
      reset = 1'b1;
      req_valid = 1'b0;
      req_button_index = 2'd0;
      req_pin_level = 1'b0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = 4'd0;
      csr_pwdata = 32'd0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // Every transition with short limits
      apply_limits(8'd2, 8'd3, 1'b0);
      for (int i = 0; i < 24; i++) send_tick(dir_btn[i], dir_pin[i]);
      drain();

      // Random phases, extremes of the limits among them
      run_phase(8'd3, 8'd6, 1'b1, 250, 1'b0);
      run_phase(8'd1, 8'd0, 1'b0, 200, 1'b0);
      run_phase(8'd0, 8'd1, 1'b1, 300, 1'b0);
      run_phase(8'd255, 8'd255, 1'b0, 300, 1'b0);
      run_phase(8'd2, 8'd255, 1'b1, 300, 1'b0);
      run_phase(8'($urandom_range(1, 6)), 8'($urandom_range(0, 8)),
                1'($urandom_range(0, 1)), 100, 1'b1);

      drain();
      if (sb.outstanding() != 0)
         sb.flag($sformatf("%0d results never arrived", sb.outstanding()));
      if (sb.fail_count == 0)
         $display("** button_debounce_hold_fsm_top: PASSED **");
      else
         $display("** button_debounce_hold_fsm_top: FAILED **");
      $finish;
   end

endmodule
